[rtl/assert_macros.svh]
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/dlt_pkg.sv]
package dlt_pkg;

	localparam int MAX_NUMBERS     = 4;
	localparam int FRACTION_DIGITS = 6;
	localparam int INTEGER_BITS    = 16;

	localparam int FRAC_BITS = 16;
	localparam int OUT_W     = 32;

	function automatic longint pow10(input int n);
		longint r;
		r = 1;
		for (int i = 0; i < n; i++) begin
			r = r * 10;
		end
		return r;
	endfunction

	localparam longint FRAC_SCALE_MAX = pow10(FRACTION_DIGITS);
	localparam int FW  = $clog2(FRAC_SCALE_MAX);
	localparam int PW  = $clog2(FRAC_SCALE_MAX + 1);
	localparam int DW  = $clog2(FRACTION_DIGITS + 1);
	localparam int CW  = $clog2(MAX_NUMBERS + 1);
	localparam int QW  = FRAC_BITS + 1;
	localparam int NW  = FW + FRAC_BITS + 1;
	localparam int TW  = INTEGER_BITS + FRAC_BITS + 1;
	localparam int SW  = (TW > OUT_W + 1) ? TW : OUT_W + 1;
	localparam int QCW = $clog2(QW);

	localparam int QUEUE_DEPTH = 4;
	localparam int QPW = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;
	localparam logic [7:0] CHAR_POINT = 8'h2E;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_MALFORMED = 2'd1;
	localparam logic [1:0] STATUS_TOO_MANY  = 2'd2;
	localparam logic [1:0] STATUS_TOO_FEW   = 2'd3;

	localparam logic KIND_NUMBER = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	typedef struct packed {
		logic                    has_num;
		logic                    has_stat;
		logic [INTEGER_BITS-1:0] int_part;
		logic [FW-1:0]           frac;
		logic [DW-1:0]           ndig;
		logic [1:0]              index;
		logic [1:0]              status;
	} job_t;

	function automatic logic [PW-1:0] frac_scale(input logic [DW-1:0] n);
		logic [PW-1:0] r;
		case (int'(n))
			0:       r = PW'(1);
			1:       r = PW'(10);
			2:       r = PW'(100);
			3:       r = PW'(1000);
			4:       r = PW'(10000);
			5:       r = PW'(100000);
			6:       r = PW'(1000000);
			default: r = PW'(1);
		endcase
		return r;
	endfunction

endpackage

[rtl/decimal_list_tokenizer.sv]
// Pulls unsigned decimal numbers out of a byte stream and returns each one as
// a Q16.16 value with its position, followed by an end status at the last byte.
// The scanner takes one byte per cycle as long as its four-entry job queue has
// room; a byte that ends the text, or a number within the expected count,
// posts one job. The converter drains the queue: a number passes through its
// one-bit-per-step divider before the result appears, and a status result
// appears in the cycle after its job is taken. The converter takes no new job
// until the last one has been divided, shown and popped, so sustained
// throughput is set by how many numbers the text holds and how soon results are popped.
module decimal_list_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  char_code,
	input  logic [2:0]  expected_count,
	input  logic        end_of_text,
	output logic        empty,
	input  logic        pop,
	output logic        kind,
	output logic [31:0] fixed_value,
	output logic [1:0]  value_index,
	output logic [1:0]  status,
	output logic        last_result
);

	logic          accept;
	logic          job_push;
	dlt_pkg::job_t job_in;
	dlt_pkg::job_t job_out;
	logic          q_empty;
	logic          q_pop;

	assign accept = push && !full;

	dlt_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.char_code      (char_code),
		.expected_count (expected_count),
		.end_of_text    (end_of_text),
		.job_push       (job_push),
		.job            (job_in)
	);

	dlt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_push),
		.wr_job (job_in),
		.full   (full),
		.rd_en  (q_pop),
		.rd_job (job_out),
		.empty  (q_empty)
	);

	dlt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_empty     (q_empty),
		.q_job       (job_out),
		.q_pop       (q_pop),
		.empty       (empty),
		.pop         (pop),
		.kind        (kind),
		.fixed_value (fixed_value),
		.value_index (value_index),
		.status      (status),
		.last_result (last_result)
	);

endmodule

[rtl/dlt_front.sv]
module dlt_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        char_code,
	input  logic [2:0]        expected_count,
	input  logic              end_of_text,
	output logic              job_push,
	output dlt_pkg::job_t     job
);

	localparam int EW = dlt_pkg::CW + 3;

	logic [dlt_pkg::INTEGER_BITS-1:0] int_q, int_n;
	logic [dlt_pkg::FW-1:0]           frac_q, frac_n;
	logic [dlt_pkg::DW-1:0]           ndig_q, ndig_n;
	logic                             inside_q, point_q, stop_q, digit_q;
	logic                             point_n, stop_n, digit_n;
	logic [dlt_pkg::CW-1:0]           nf_q, nf_n;
	logic                             malformed_q, too_many_q;
	logic                             malformed_n, too_many_n;

	logic                             is_digit, is_point, is_num, fin;
	logic                             over, emit;
	logic [3:0]                       d;
	logic [dlt_pkg::INTEGER_BITS+3:0] int_mul;
	logic [dlt_pkg::FW+3:0]           frac_mul;
	logic [EW-1:0]                    exp_w, exp_c, nf_w, nfn_w;
	logic [1:0]                       st;

	always_comb begin
		is_digit = (char_code >= dlt_pkg::CHAR_ZERO) && (char_code <= dlt_pkg::CHAR_NINE);
		is_point = char_code == dlt_pkg::CHAR_POINT;
		is_num   = is_digit || is_point;
		d        = 4'(char_code - dlt_pkg::CHAR_ZERO);

		int_mul  = ({4'b0, int_q} << 3) + ({4'b0, int_q} << 1) + (dlt_pkg::INTEGER_BITS + 4)'(d);
		frac_mul = ({4'b0, frac_q} << 3) + ({4'b0, frac_q} << 1) + (dlt_pkg::FW + 4)'(d);

		int_n   = int_q;
		frac_n  = frac_q;
		ndig_n  = ndig_q;
		point_n = point_q;
		stop_n  = stop_q;
		digit_n = digit_q;
		if (is_num && !stop_q) begin
			if (is_point) begin
				if (point_q) begin
					stop_n = 1'b1;
				end else begin
					point_n = 1'b1;
				end
			end else begin
				digit_n = 1'b1;
				if (!point_q) begin
					if (|int_mul[dlt_pkg::INTEGER_BITS+3:dlt_pkg::INTEGER_BITS]) begin
						int_n = '1;
					end else begin
						int_n = int_mul[dlt_pkg::INTEGER_BITS-1:0];
					end
				end else if (int'(ndig_q) < dlt_pkg::FRACTION_DIGITS) begin
					frac_n = frac_mul[dlt_pkg::FW-1:0];
					ndig_n = ndig_q + dlt_pkg::DW'(1);
				end
			end
		end

		exp_w = EW'(expected_count);
		exp_c = (exp_w > EW'(dlt_pkg::MAX_NUMBERS)) ? EW'(dlt_pkg::MAX_NUMBERS) : exp_w;
		nf_w  = EW'(nf_q);

		fin         = (is_num && end_of_text) || (!is_num && inside_q);
		over        = nf_w >= exp_c;
		emit        = fin && !over && digit_n;
		malformed_n = malformed_q || (fin && !over && !digit_n);
		too_many_n  = too_many_q || (fin && over);
		nf_n        = emit ? nf_q + dlt_pkg::CW'(1) : nf_q;
		nfn_w       = EW'(nf_n);

		if (malformed_n) begin
			st = dlt_pkg::STATUS_MALFORMED;
		end else if (too_many_n) begin
			st = dlt_pkg::STATUS_TOO_MANY;
		end else if (nfn_w < exp_c) begin
			st = dlt_pkg::STATUS_TOO_FEW;
		end else begin
			st = dlt_pkg::STATUS_OK;
		end

		job_push      = accept && (emit || end_of_text);
		job.has_num   = emit;
		job.has_stat  = end_of_text;
		job.int_part  = int_n;
		job.frac      = frac_n;
		job.ndig      = ndig_n;
		job.index     = nf_q[1:0];
		job.status    = st;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			int_q       <= '0;
			frac_q      <= '0;
			ndig_q      <= '0;
			inside_q    <= 1'b0;
			point_q     <= 1'b0;
			stop_q      <= 1'b0;
			digit_q     <= 1'b0;
			nf_q        <= '0;
			malformed_q <= 1'b0;
			too_many_q  <= 1'b0;
		end else if (accept) begin
			if (end_of_text || fin) begin
				int_q    <= '0;
				frac_q   <= '0;
				ndig_q   <= '0;
				inside_q <= 1'b0;
				point_q  <= 1'b0;
				stop_q   <= 1'b0;
				digit_q  <= 1'b0;
			end else begin
				int_q    <= int_n;
				frac_q   <= frac_n;
				ndig_q   <= ndig_n;
				inside_q <= inside_q || is_num;
				point_q  <= point_n;
				stop_q   <= stop_n;
				digit_q  <= digit_n;
			end
			if (end_of_text) begin
				nf_q        <= '0;
				malformed_q <= 1'b0;
				too_many_q  <= 1'b0;
			end else begin
				nf_q        <= nf_n;
				malformed_q <= malformed_n;
				too_many_q  <= too_many_n;
			end
		end
	end

endmodule

[rtl/dlt_queue.sv]
module dlt_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  dlt_pkg::job_t wr_job,
	output logic          full,
	input  logic          rd_en,
	output dlt_pkg::job_t rd_job,
	output logic          empty
);

	dlt_pkg::job_t             slot_q [dlt_pkg::QUEUE_DEPTH];
	logic [dlt_pkg::QPW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [dlt_pkg::QPW:0]     cnt_q;

	assign full   = cnt_q == (dlt_pkg::QPW + 1)'(dlt_pkg::QUEUE_DEPTH);
	assign empty  = cnt_q == '0;
	assign rd_job = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + dlt_pkg::QPW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + dlt_pkg::QPW'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + (dlt_pkg::QPW + 1)'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - (dlt_pkg::QPW + 1)'(1);
			end
		end
	end

endmodule

[rtl/dlt_back.sv]
module dlt_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  dlt_pkg::job_t q_job,
	output logic          q_pop,
	output logic          empty,
	input  logic          pop,
	output logic          kind,
	output logic [31:0]   fixed_value,
	output logic [1:0]    value_index,
	output logic [1:0]    status,
	output logic          last_result
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_NUM,
		ST_STAT
	} state_t;

	state_t                           state_q;
	logic [dlt_pkg::QCW-1:0]          cnt_q;
	logic [dlt_pkg::PW-1:0]           p_q, rem_q, rem_n;
	logic [dlt_pkg::QW-1:0]           num_q, quo_q, quo_n;
	logic [dlt_pkg::INTEGER_BITS-1:0] int_q;
	logic                             has_stat_q;
	logic [1:0]                       stat_q;

	logic [dlt_pkg::PW:0]             trial;
	logic                             ge;
	logic [dlt_pkg::PW-1:0]           scale;
	logic [dlt_pkg::NW-1:0]           numer;
	logic [dlt_pkg::SW-1:0]           total;
	logic [31:0]                      value;

	always_comb begin
		trial = {rem_q, num_q[dlt_pkg::QW-1]};
		ge    = trial >= {1'b0, p_q};
		rem_n = ge ? dlt_pkg::PW'(trial - {1'b0, p_q}) : trial[dlt_pkg::PW-1:0];
		quo_n = {quo_q[dlt_pkg::QW-2:0], ge};

		scale = dlt_pkg::frac_scale(q_job.ndig);
		numer = (dlt_pkg::NW'(q_job.frac) << dlt_pkg::FRAC_BITS) + dlt_pkg::NW'(scale >> 1);

		total = (dlt_pkg::SW'(int_q) << dlt_pkg::FRAC_BITS) + dlt_pkg::SW'(quo_n);
		value = (|total[dlt_pkg::SW-1:32]) ? '1 : total[31:0];

		q_pop = (state_q == ST_IDLE) && !q_empty;
		empty = !((state_q == ST_NUM) || (state_q == ST_STAT));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			p_q         <= '0;
			rem_q       <= '0;
			num_q       <= '0;
			quo_q       <= '0;
			int_q       <= '0;
			has_stat_q  <= 1'b0;
			stat_q      <= '0;
			kind        <= 1'b0;
			fixed_value <= '0;
			value_index <= '0;
			status      <= '0;
			last_result <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						has_stat_q <= q_job.has_stat;
						stat_q     <= q_job.status;
						if (q_job.has_num) begin
							int_q       <= q_job.int_part;
							p_q         <= scale;
							rem_q       <= dlt_pkg::PW'(numer[dlt_pkg::NW-1:dlt_pkg::QW]);
							num_q       <= numer[dlt_pkg::QW-1:0];
							quo_q       <= '0;
							cnt_q       <= '0;
							value_index <= q_job.index;
							state_q     <= ST_DIV;
						end else begin
							kind        <= dlt_pkg::KIND_STATUS;
							fixed_value <= '0;
							value_index <= '0;
							status      <= q_job.status;
							last_result <= 1'b1;
							state_q     <= ST_STAT;
						end
					end
				end
				ST_DIV: begin
					rem_q <= rem_n;
					num_q <= num_q << 1;
					quo_q <= quo_n;
					cnt_q <= cnt_q + dlt_pkg::QCW'(1);
					if (cnt_q == dlt_pkg::QCW'(dlt_pkg::QW - 1)) begin
						kind        <= dlt_pkg::KIND_NUMBER;
						fixed_value <= value;
						status      <= dlt_pkg::STATUS_OK;
						last_result <= !has_stat_q;
						state_q     <= ST_NUM;
					end
				end
				ST_NUM: begin
					if (pop) begin
						if (has_stat_q) begin
							kind        <= dlt_pkg::KIND_STATUS;
							fixed_value <= '0;
							value_index <= '0;
							status      <= stat_q;
							last_result <= 1'b1;
							state_q     <= ST_STAT;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_STAT: begin
					if (pop) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/dlt_checker.sv]
`include "assert_macros.svh"

module dlt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic        kind,
	input logic [31:0] fixed_value,
	input logic [1:0]  value_index,
	input logic [1:0]  status,
	input logic        last_result
);

	logic show_stat;
	logic show_num;
	logic held;

	assign show_stat = !empty && (kind == dlt_pkg::KIND_STATUS);
	assign show_num  = !empty && (kind == dlt_pkg::KIND_NUMBER);
	assign held      = !empty && !pop;

	`ASSERT_SAME(a_stat_clean, clk, arst_n, show_stat, fixed_value == '0 && value_index == '0 && last_result)
	`ASSERT_SAME(a_num_status_ok, clk, arst_n, show_num, status == dlt_pkg::STATUS_OK)
	`ASSERT_NEXT(a_num_not_last, clk, arst_n, show_num && !last_result && pop, empty || kind == dlt_pkg::KIND_STATUS)
	`ASSERT_NEXT(a_hold, clk, arst_n, held, !empty && $stable(fixed_value) && $stable(kind))

endmodule

bind decimal_list_tokenizer dlt_checker u_dlt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.empty       (empty),
	.pop         (pop),
	.kind        (kind),
	.fixed_value (fixed_value),
	.value_index (value_index),
	.status      (status),
	.last_result (last_result)
);

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

	typedef struct packed {
		logic        kind;
		logic [31:0] value;
		logic [1:0]  index;
		logic [1:0]  status;
		logic        last;
	} token_result_t;

	class number_board;
		token_result_t pending[$];
		token_result_t staged[$];
		int failures;
		int reported;

		logic [dlt_pkg::INTEGER_BITS-1:0] int_acc;
		logic [19:0]             frac_acc;
		logic [2:0]              frac_cnt;
		logic                    in_token;
		logic                    has_point;
		logic                    stopped;
		logic                    saw_digit;
		logic [2:0]              found;
		logic [1:0]              flags;

		function new();
			failures = 0;
			reported = 0;
			clear_text();
		endfunction

		function void clear_token();
			int_acc = '0;
			frac_acc = '0;
			frac_cnt = '0;
			in_token = 1'b0;
			has_point = 1'b0;
			stopped = 1'b0;
			saw_digit = 1'b0;
		endfunction

		function void clear_text();
			clear_token();
			found = '0;
			flags = '0;
		endfunction

		function int outstanding();
			return pending.size();
		endfunction

		function token_result_t make_result(logic kind, logic [31:0] value,
				logic [1:0] index, logic [1:0] status);
			token_result_t r;
			r.kind = kind;
			r.value = value;
			r.index = index;
			r.status = status;
			r.last = 1'b0;
			return r;
		endfunction

		function logic [31:0] q16_of_token();
			longint unsigned scale;
			longint unsigned frac_q;
			longint unsigned total;
			scale = 1;
			repeat (frac_cnt) scale = scale * 10;
			frac_q = ((64'(frac_acc) * 65536) + scale / 2) / scale;
			total = (64'(int_acc) << 16) + frac_q;
			if (total > 64'hFFFF_FFFF) total = 64'hFFFF_FFFF;
			return total[31:0];
		endfunction

		function void close_token(int want);
			if (int'(found) >= want) begin
				flags[1] = 1'b1;
			end else if (!saw_digit) begin
				flags[0] = 1'b1;
			end else begin
				staged.push_back(make_result(dlt_pkg::KIND_NUMBER, q16_of_token(),
					found[1:0], dlt_pkg::STATUS_OK));
				found = found + 3'd1;
			end
			clear_token();
		endfunction

		function void take_char(logic [7:0] ch, logic [2:0] want_in, logic eot);
			int want;
			bit digit;
			bit numeric;
			int unsigned grown;
			int unsigned int_max;
			logic [1:0] st;
			token_result_t tail;
			int_max = (1 << dlt_pkg::INTEGER_BITS) - 1;
			want = (int'(want_in) > dlt_pkg::MAX_NUMBERS) ? dlt_pkg::MAX_NUMBERS
				: int'(want_in);
			digit = (ch >= dlt_pkg::CHAR_ZERO) && (ch <= dlt_pkg::CHAR_NINE);
			numeric = digit || (ch == dlt_pkg::CHAR_POINT);
			staged.delete();
			if (numeric) begin
				in_token = 1'b1;
				if (!stopped) begin
					if (!digit) begin
						if (has_point) stopped = 1'b1;
						else has_point = 1'b1;
					end else begin
						saw_digit = 1'b1;
						if (!has_point) begin
							grown = int_acc * 10 + (ch - dlt_pkg::CHAR_ZERO);
							int_acc = (grown > int_max) ? int_max : grown;
						end else if (frac_cnt < dlt_pkg::FRACTION_DIGITS) begin
							frac_acc = frac_acc * 10 + (ch - dlt_pkg::CHAR_ZERO);
							frac_cnt = frac_cnt + 3'd1;
						end
					end
				end
				if (eot) close_token(want);
			end else if (in_token) begin
				close_token(want);
			end
			if (eot) begin
				if (flags[0]) st = dlt_pkg::STATUS_MALFORMED;
				else if (flags[1]) st = dlt_pkg::STATUS_TOO_MANY;
				else if (int'(found) < want) st = dlt_pkg::STATUS_TOO_FEW;
				else st = dlt_pkg::STATUS_OK;
				staged.push_back(make_result(dlt_pkg::KIND_STATUS, 32'd0, 2'd0, st));
				clear_text();
			end
			if (staged.size() > 0) begin
				tail = staged[staged.size() - 1];
				tail.last = 1'b1;
				staged[staged.size() - 1] = tail;
			end
			foreach (staged[i]) pending.push_back(staged[i]);
		endfunction

		function void match_result(token_result_t got);
			token_result_t want;
			if (pending.size() == 0) begin
				failures++;
				if (reported < 10) begin
					reported++;
					$display("unexpected result: kind=%0d value=%h index=%0d status=%0d last=%0d",
						got.kind, got.value, got.index, got.status, got.last);
				end
				return;
			end
			want = pending.pop_front();
			if (got.kind !== want.kind || got.value !== want.value ||
					got.index !== want.index || got.status !== want.status ||
					got.last !== want.last) begin
				failures++;
				if (reported < 10) begin
					reported++;
					$display("mismatch: expected kind=%0d value=%h index=%0d status=%0d last=%0d",
						want.kind, want.value, want.index, want.status, want.last);
					$display("          actual   kind=%0d value=%h index=%0d status=%0d last=%0d",
						got.kind, got.value, got.index, got.status, got.last);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  char_code;
	logic [2:0]  expected_count;
	logic        end_of_text;
	logic        empty;
	logic        pop;
	logic        kind;
	logic [31:0] fixed_value;
	logic [1:0]  value_index;
	logic [1:0]  status;
	logic        last_result;

	number_board board;
	logic [7:0]  text_buf[$];
	int          items_sent;
	int          burst_left;
	bit          no_gaps;
	bit          hold_req;

	decimal_list_tokenizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.char_code(char_code),
		.expected_count(expected_count),
		.end_of_text(end_of_text),
		.empty(empty),
		.pop(pop),
		.kind(kind),
		.fixed_value(fixed_value),
		.value_index(value_index),
		.status(status),
		.last_result(last_result)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		token_result_t got;
		if (arst_n === 1'b1 && pop === 1'b1 && empty === 1'b0) begin
			got.kind = kind;
			got.value = fixed_value;
			got.index = value_index;
			got.status = status;
			got.last = last_result;
			board.match_result(got);
		end
	end

	task automatic drive_char(logic [7:0] ch, logic [2:0] want, logic eot);
		int gap;
		if (burst_left == 0) begin
			gap = no_gaps ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12));
			repeat (gap) begin
				@(negedge clk);
				push <= 1'b0;
			end
			burst_left = $urandom_range(1, 30);
		end
		burst_left--;
		@(negedge clk);
		push <= 1'b1;
		char_code <= ch;
		expected_count <= want;
		end_of_text <= eot;
		@(posedge clk);
		while (full !== 1'b0) @(posedge clk);
		board.take_char(ch, want, eot);
		items_sent++;
	endtask

	task automatic send_text(logic [2:0] want, bit vary_want);
		logic [2:0] w;
		for (int i = 0; i < text_buf.size(); i++) begin
			w = (vary_want && $urandom_range(0, 39) == 0) ? 3'($urandom_range(0, 7)) : want;
			drive_char(text_buf[i], w, i == text_buf.size() - 1);
		end
		text_buf.delete();
	endtask

	task automatic send_literal(string s, logic [2:0] want);
		for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
		send_text(want, 1'b0);
	endtask

	task automatic add_digits(int n);
		repeat (n) text_buf.push_back(8'(dlt_pkg::CHAR_ZERO + $urandom_range(0, 9)));
	endtask

	task automatic add_separator();
		logic [7:0] seps[5];
		logic [7:0] b;
		seps = '{",", " ", "-", "{", "}"};
		if ($urandom_range(0, 3) == 0) begin
			do b = 8'($urandom_range(0, 255));
			while ((b >= dlt_pkg::CHAR_ZERO && b <= dlt_pkg::CHAR_NINE) ||
				b == dlt_pkg::CHAR_POINT);
			text_buf.push_back(b);
		end else begin
			text_buf.push_back(seps[$urandom_range(0, 4)]);
		end
	endtask

	task automatic add_token();
		int nint;
		int nfrac;
		bit point;
		if ($urandom_range(0, 11) == 0) begin
			text_buf.push_back(dlt_pkg::CHAR_POINT);
			if ($urandom_range(0, 1) == 1) begin
				text_buf.push_back(dlt_pkg::CHAR_POINT);
				add_digits($urandom_range(0, 2));
			end
			return;
		end
		nint = $urandom_range(0, 6);
		point = (nint == 0) || ($urandom_range(0, 9) < 6);
		add_digits(nint);
		if (point) begin
			text_buf.push_back(dlt_pkg::CHAR_POINT);
			nfrac = $urandom_range(0, 8);
			if (nint == 0 && nfrac == 0) nfrac = 1;
			add_digits(nfrac);
			if ($urandom_range(0, 9) == 0) begin
				text_buf.push_back(dlt_pkg::CHAR_POINT);
				add_digits($urandom_range(0, 3));
			end
		end
	endtask

	task automatic send_random_text();
		int n_tok;
		logic [2:0] want;
		if ($urandom_range(0, 5) == 0) begin
			repeat ($urandom_range(1, 12)) text_buf.push_back(8'($urandom_range(0, 255)));
			send_text(3'($urandom_range(0, 7)), 1'b1);
			return;
		end
		n_tok = $urandom_range(0, 5);
		if ($urandom_range(0, 4) == 0) want = 3'($urandom_range(0, 7));
		else want = 3'((n_tok < 1) ? 1 : ((n_tok > 4) ? 4 : n_tok));
		if ($urandom_range(0, 1) == 1) text_buf.push_back("{");
		for (int t = 0; t < n_tok; t++) begin
			add_token();
			if (t < n_tok - 1) begin
				add_separator();
				if ($urandom_range(0, 3) == 0) add_separator();
			end
		end
		if (text_buf.size() == 0 || $urandom_range(0, 1) == 1) add_separator();
		send_text(want, 1'b1);
	endtask

	task automatic run_random(int upto);
		while (items_sent < upto) send_random_text();
	endtask

	task automatic drain_results();
		@(negedge clk);
		push <= 1'b0;
		while (board.outstanding() != 0) @(posedge clk);
	endtask

	initial begin
		int hold_left;
		int mode;
		int mode_left;
		hold_left = 0;
		mode = 0;
		mode_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(10, 80);
				end
				mode_left--;
				case (mode)
					0: pop <= 1'b1;
					1: pop <= 1'($urandom_range(0, 1));
					2: pop <= ($urandom_range(0, 3) == 0);
					default: pop <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	initial begin
		#5_000_000;
		$display("decimal_list_tokenizer verification failed");
		$finish;
	end

	initial begin
		board = new();
		clk = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		char_code = 8'd0;
		expected_count = 3'd1;
		end_of_text = 1'b0;
		items_sent = 0;
		burst_left = 0;
		no_gaps = 1'b0;
		hold_req = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_literal("70000.999999", 3'd1);
		send_literal("..5-.", 3'd1);
		send_literal("7.1.9,8", 3'd1);
		send_literal("5", 3'd0);
		send_literal("3", 3'd7);

		run_random(150);
		hold_req = 1'b1;
		no_gaps = 1'b1;
		run_random(items_sent + 60);
		no_gaps = 1'b0;
		run_random(350);
		drain_results();
		run_random(500);
		drain_results();
		repeat (40) @(posedge clk);

		if (board.failures == 0 && board.outstanding() == 0) begin
			$display("decimal_list_tokenizer verification clean");
		end else begin
			$display("decimal_list_tokenizer verification failed");
		end
		$finish;
	end

endmodule
